[design/bcd_pkg.sv]
// Package for the bech32 character decoder: item types, result kinds,
// status codes and the alphabet lookup. Depends on nothing.
package bcd_pkg;

  // Result kinds.
  localparam logic [1:0] KIND_PREFIX = 2'd0;
  localparam logic [1:0] KIND_DATA   = 2'd1;
  localparam logic [1:0] KIND_STATUS = 2'd2;

  // End status codes.
  localparam logic [7:0] ST_OK       = 8'd0;
  localparam logic [7:0] ST_NOSEP    = 8'd1;
  localparam logic [7:0] ST_BADCHAR  = 8'd2;
  localparam logic [7:0] ST_MIXED    = 8'd3;

  // Character constants.
  localparam logic [7:0] CH_SEP   = 8'h31;
  localparam logic [7:0] CH_UP_A  = 8'h41;
  localparam logic [7:0] CH_UP_Z  = 8'h5A;
  localparam logic [7:0] CH_LO_A  = 8'h61;
  localparam logic [7:0] CH_LO_Z  = 8'h7A;
  localparam logic [7:0] CASE_OFS = 8'h20;

  // Result queue depth and pointer widths.
  localparam int QDEPTH = 4;
  localparam int QPTRW  = $clog2(QDEPTH);
  localparam int QCNTW  = $clog2(QDEPTH + 1);

  // One result item.
  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] value;
    logic       fin;
  } res_item_t;

  // Up to two results produced by one input item, in order.
  typedef struct packed {
    logic      vld0;
    res_item_t item0;
    logic      vld1;
    res_item_t item1;
  } res_pair_t;

  // Alphabet lookup: bit 5 set means the symbol is in the alphabet,
  // bits 4:0 are its 5-bit group.
  function automatic logic [5:0] sym_lookup(input logic [7:0] c);
    logic [5:0] r;
    r = 6'd0;
    case (c)
      "q": r = {1'b1, 5'd0};   "p": r = {1'b1, 5'd1};
      "z": r = {1'b1, 5'd2};   "r": r = {1'b1, 5'd3};
      "y": r = {1'b1, 5'd4};   "9": r = {1'b1, 5'd5};
      "x": r = {1'b1, 5'd6};   "8": r = {1'b1, 5'd7};
      "g": r = {1'b1, 5'd8};   "f": r = {1'b1, 5'd9};
      "2": r = {1'b1, 5'd10};  "t": r = {1'b1, 5'd11};
      "v": r = {1'b1, 5'd12};  "d": r = {1'b1, 5'd13};
      "w": r = {1'b1, 5'd14};  "0": r = {1'b1, 5'd15};
      "s": r = {1'b1, 5'd16};  "3": r = {1'b1, 5'd17};
      "j": r = {1'b1, 5'd18};  "n": r = {1'b1, 5'd19};
      "5": r = {1'b1, 5'd20};  "4": r = {1'b1, 5'd21};
      "k": r = {1'b1, 5'd22};  "h": r = {1'b1, 5'd23};
      "c": r = {1'b1, 5'd24};  "e": r = {1'b1, 5'd25};
      "6": r = {1'b1, 5'd26};  "m": r = {1'b1, 5'd27};
      "u": r = {1'b1, 5'd28};  "a": r = {1'b1, 5'd29};
      "7": r = {1'b1, 5'd30};  "l": r = {1'b1, 5'd31};
      default: r = 6'd0;
    endcase
    return r;
  endfunction

endpackage

[design/bcd_decode.sv]
// Per-character decode step and string state of the bech32 decoder.
// Depends on bcd_pkg.
module bcd_decode (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              step,
  input  logic [7:0]        ch,
  input  logic              last_char,
  output bcd_pkg::res_pair_t res
);

  logic       sep_r, up_r, lo_r, bad_r;
  logic [6:0] bits_r;
  logic [2:0] cnt_r;
  logic       sep_nxt, up_nxt, lo_nxt, bad_nxt;
  logic [6:0] bits_nxt;
  logic [2:0] cnt_nxt;

  logic        is_up, is_lo, err;
  logic [7:0]  folded;
  logic [5:0]  sym;
  logic [11:0] acc;
  logic [3:0]  cnt_sum;
  logic [2:0]  cnt_rem;
  logic [11:0] acc_sh;
  logic [7:0]  status;

  // Case folding, alphabet lookup and bit packing for one character.
  always_comb begin
    is_up   = (ch >= bcd_pkg::CH_UP_A) && (ch <= bcd_pkg::CH_UP_Z);
    is_lo   = (ch >= bcd_pkg::CH_LO_A) && (ch <= bcd_pkg::CH_LO_Z);
    folded  = is_up ? ch + bcd_pkg::CASE_OFS : ch;
    sym     = bcd_pkg::sym_lookup(folded);
    acc     = {bits_r, sym[4:0]};
    cnt_sum = {1'b0, cnt_r} + 4'd5;
    cnt_rem = cnt_sum[2:0];
    acc_sh  = acc >> cnt_rem;

    sep_nxt  = sep_r;
    up_nxt   = up_r | is_up;
    lo_nxt   = lo_r | is_lo;
    bad_nxt  = bad_r;
    bits_nxt = bits_r;
    cnt_nxt  = cnt_r;
    err      = bad_r || (up_nxt && lo_nxt);
    res      = '0;

    if (!sep_r) begin
      if (ch == bcd_pkg::CH_SEP) begin
        sep_nxt = 1'b1;
      end else if (!(up_nxt && lo_nxt)) begin
        res.vld0        = 1'b1;
        res.item0.kind  = bcd_pkg::KIND_PREFIX;
        res.item0.value = folded;
      end
    end else if (!sym[5]) begin
      // Bytes above 127 never match the alphabet either.
      bad_nxt = 1'b1;
    end else begin
      if (!err) begin
        if (cnt_sum[3]) begin
          res.vld0        = 1'b1;
          res.item0.kind  = bcd_pkg::KIND_DATA;
          res.item0.value = acc_sh[7:0];
          cnt_nxt         = cnt_rem;
          bits_nxt        = acc[6:0] & ((7'd1 << cnt_rem) - 7'd1);
        end else begin
          cnt_nxt  = cnt_sum[2:0];
          bits_nxt = acc[6:0];
        end
      end
    end

    // End status, taken from the state this character leaves.
    if (!sep_nxt) begin
      status = bcd_pkg::ST_NOSEP;
    end else if (bad_nxt) begin
      status = bcd_pkg::ST_BADCHAR;
    end else if (up_nxt && lo_nxt) begin
      status = bcd_pkg::ST_MIXED;
    end else begin
      status = bcd_pkg::ST_OK;
    end
    res.vld1        = last_char;
    res.item1.kind  = bcd_pkg::KIND_STATUS;
    res.item1.value = status;
    res.item1.fin   = 1'b1;
  end

  // String state; cleared after the last character of a string.
  always_ff @(posedge clk) begin
    if (!rst_n || (step && last_char)) begin
      sep_r  <= 1'b0;
      up_r   <= 1'b0;
      lo_r   <= 1'b0;
      bad_r  <= 1'b0;
      bits_r <= '0;
      cnt_r  <= '0;
    end else if (step) begin
      sep_r  <= sep_nxt;
      up_r   <= up_nxt;
      lo_r   <= lo_nxt;
      bad_r  <= bad_nxt;
      bits_r <= bits_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

endmodule

[design/bcd_outq.sv]
// Result queue of the bech32 decoder: takes up to two items a cycle and
// hands out one. Depends on bcd_pkg.
module bcd_outq (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  push,
  input  bcd_pkg::res_pair_t    res,
  output logic                  room2,
  output logic                  out_valid,
  input  logic                  out_ready,
  output bcd_pkg::res_item_t    out_item,
  output logic [bcd_pkg::QCNTW-1:0] level
);

  bcd_pkg::res_item_t mem_r [bcd_pkg::QDEPTH];
  logic [bcd_pkg::QPTRW-1:0] wr_r, rd_r, wr_nxt, rd_nxt, wr_p1;
  logic [bcd_pkg::QCNTW-1:0] cnt_r, cnt_nxt;
  logic [1:0]                n_in;
  logic                      pop;
  bcd_pkg::res_item_t        first;

  assign pop       = out_valid && out_ready;
  assign out_valid = (cnt_r != '0);
  assign out_item  = mem_r[rd_r];
  assign room2     = (cnt_r <= bcd_pkg::QCNTW'(bcd_pkg::QDEPTH - 2));
  assign level     = cnt_r;

  // Pointer and fill bookkeeping.
  always_comb begin
    n_in    = push ? ({1'b0, res.vld0} + {1'b0, res.vld1}) : 2'd0;
    first   = res.vld0 ? res.item0 : res.item1;
    wr_p1   = wr_r + 1'b1;
    wr_nxt  = wr_r + bcd_pkg::QPTRW'(n_in);
    rd_nxt  = pop ? rd_r + 1'b1 : rd_r;
    cnt_nxt = cnt_r + bcd_pkg::QCNTW'(n_in) - bcd_pkg::QCNTW'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      wr_r  <= wr_nxt;
      rd_r  <= rd_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  // Entry writes: the first item at the tail, the status after it.
  always_ff @(posedge clk) begin
    if (n_in != 2'd0) begin
      mem_r[wr_r] <= first;
    end
    if (n_in == 2'd2) begin
      mem_r[wr_p1] <= res.item1;
    end
  end

endmodule

[design/bech32_charset_decode.sv]
// Top level of the streaming bech32 string decoder (no checksum check).
// Depends on bcd_pkg, bcd_decode and bcd_outq.
//
//  channel  direction  ports                               item
//  in       input      in_valid/in_ready, in_ch, in_last_char   one character
//  out      output     out_valid/out_ready, out_kind,
//                      out_value, out_final_res                 one result
//
// A character is registered on acceptance, decoded from the input register
// once the queue has room for two items, and its results are written to the queue.
// One character is taken per cycle while the queue holds two items or fewer.
// Only the last character of a string gives two results, so with no output
// stalls there is at most one input stall per string, when the four-entry
// queue is three deep.
// Reset is synchronous and active low and empties the input register,
// the queue and the string state. A stalled output holds the queue head.
module bech32_charset_decode (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_ch,
  input  logic       in_last_char,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [1:0] out_kind,
  output logic [7:0] out_value,
  output logic       out_final_res
);

  logic       vld_r;
  logic [7:0] ch_r;
  logic       last_r;
  logic       step, room2;
  bcd_pkg::res_pair_t res;
  bcd_pkg::res_item_t head;
  logic [bcd_pkg::QCNTW-1:0] level;

  assign step     = vld_r && room2;
  assign in_ready = !vld_r || step;

  // Input register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (in_ready) begin
      vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      ch_r   <= in_ch;
      last_r <= in_last_char;
    end
  end

  bcd_decode u_decode (
    .clk       (clk),
    .rst_n     (rst_n),
    .step      (step),
    .ch        (ch_r),
    .last_char (last_r),
    .res       (res)
  );

  bcd_outq u_outq (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (step),
    .res       (res),
    .room2     (room2),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (head),
    .level     (level)
  );

  assign out_kind      = head.kind;
  assign out_value     = head.value;
  assign out_final_res = head.fin;

  // The queue never holds more items than it has entries.
  a_level: assert property (@(posedge clk) disable iff (!rst_n)
    level <= bcd_pkg::QCNTW'(bcd_pkg::QDEPTH))
    else $error("result queue overfilled");

  // Only an end status closes a string.
  a_fin: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_final_res == (out_kind == bcd_pkg::KIND_STATUS)))
    else $error("final flag on a non-status result");

  // A held character stays in the input register until it is decoded.
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (vld_r && !step) |=> (vld_r && $stable(ch_r) && $stable(last_r)))
    else $error("input register lost a character");

  // A decoded last character always yields a status result.
  a_status: assert property (@(posedge clk) disable iff (!rst_n)
    (step && last_r) |-> res.vld1)
    else $error("missing end status");

endmodule

[sim/bcd_checker.sv]
// Result checker for the bech32 character decoder: watches both channels,
// predicts the results of every accepted character and compares them.
// Depends on bcd_pkg for the result type, kinds, status codes and characters.
module bcd_checker (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  input  logic       in_ready,
  input  logic [7:0] in_ch,
  input  logic       in_last_char,
  input  logic       out_valid,
  input  logic       out_ready,
  input  logic [1:0] out_kind,
  input  logic [7:0] out_value,
  input  logic       out_final_res,
  output int         fail_count,
  output int         outstanding
);
  timeunit 1ns;
  timeprecision 1ps;

  // The 32 data symbols, symbol 0 in the leftmost byte.
  localparam logic [255:0] BECH_SYMBOLS = "qpzry9x8gf2tvdw0s3jn54khce6mua7l";

  // Results still owed by the decoder, oldest first.
  bcd_pkg::res_item_t owed_results[$];
  bcd_pkg::res_item_t oldest;

  // Predicted string state.
  logic       sep_seen;
  logic       upper_seen;
  logic       lower_seen;
  logic       char_bad;
  logic [6:0] spare_bits;
  logic [2:0] spare_count;

  initial begin
    fail_count  = 0;
    outstanding = 0;
  end

  // Prints one line per mismatch, up to a cap, and counts them all.
  task automatic report_mismatch(input string what, input int got, input int want);
    if (fail_count < 40) begin
      $display("%0t ns: mismatch in %s: got %0d, expected %0d", $time, what, got, want);
    end
    fail_count++;
  endtask

  // Returns {found, group} for a folded character.
  function automatic logic [5:0] find_symbol(input logic [7:0] c);
    logic [5:0] hit;
    hit = 6'd0;
    for (int i = 0; i < 32; i++) begin
      if (BECH_SYMBOLS[8 * (31 - i) +: 8] == c) begin
        hit = {1'b1, 5'(i)};
      end
    end
    return hit;
  endfunction

  function automatic logic string_broken();
    return char_bad || (upper_seen && lower_seen);
  endfunction

  task automatic owe(input logic [1:0] kind, input logic [7:0] value, input logic fin);
    bcd_pkg::res_item_t r;
    r.kind  = kind;
    r.value = value;
    r.fin   = fin;
    owed_results.push_back(r);
  endtask

  // Works out the results of one accepted character and updates the state.
  task automatic decode_char(input logic [7:0] c, input logic last);
    logic [7:0]  folded;
    logic [5:0]  hit;
    logic [11:0] acc;
    logic [3:0]  cnt;
    logic [7:0]  mask;
    logic [7:0]  status;
    folded = c;
    if (c >= bcd_pkg::CH_UP_A && c <= bcd_pkg::CH_UP_Z) begin
      upper_seen = 1'b1;
      folded     = c + bcd_pkg::CASE_OFS;
    end else if (c >= bcd_pkg::CH_LO_A && c <= bcd_pkg::CH_LO_Z) begin
      lower_seen = 1'b1;
    end

    if (!sep_seen) begin
      // Human-readable part: everything up to the first separator.
      if (c == bcd_pkg::CH_SEP) begin
        sep_seen = 1'b1;
      end else if (!string_broken()) begin
        owe(bcd_pkg::KIND_PREFIX, folded, 1'b0);
      end
    end else begin
      // Data part: bytes above 127 never match a symbol, so they are bad too.
      hit = find_symbol(folded);
      if (!hit[5]) begin
        char_bad = 1'b1;
      end else if (!string_broken()) begin
        acc = {spare_bits, hit[4:0]};
        cnt = {1'b0, spare_count} + 4'd5;
        if (cnt >= 4'd8) begin
          cnt = cnt - 4'd8;
          owe(bcd_pkg::KIND_DATA, 8'(acc >> cnt), 1'b0);
        end
        mask        = (8'd1 << cnt) - 8'd1;
        spare_count = cnt[2:0];
        spare_bits  = acc[6:0] & mask[6:0];
      end
    end

    // The end status closes the string and clears everything.
    if (last) begin
      if (!sep_seen) begin
        status = bcd_pkg::ST_NOSEP;
      end else if (char_bad) begin
        status = bcd_pkg::ST_BADCHAR;
      end else if (upper_seen && lower_seen) begin
        status = bcd_pkg::ST_MIXED;
      end else begin
        status = bcd_pkg::ST_OK;
      end
      owe(bcd_pkg::KIND_STATUS, status, 1'b1);
      sep_seen    = 1'b0;
      upper_seen  = 1'b0;
      lower_seen  = 1'b0;
      char_bad    = 1'b0;
      spare_bits  = 7'd0;
      spare_count = 3'd0;
    end
  endtask

  // A result can never come from the character accepted at the same edge,
  // so the comparison goes first.
  always @(posedge clk) begin
    if (!rst_n) begin
      owed_results.delete();
      sep_seen    = 1'b0;
      upper_seen  = 1'b0;
      lower_seen  = 1'b0;
      char_bad    = 1'b0;
      spare_bits  = 7'd0;
      spare_count = 3'd0;
    end else begin
      if (out_valid && out_ready) begin
        if (owed_results.size() == 0) begin
          report_mismatch("result with nothing owed, value", out_value, 0);
        end else begin
          oldest = owed_results.pop_front();
          if (out_kind !== oldest.kind) begin
            report_mismatch("kind", out_kind, oldest.kind);
          end
          if (out_value !== oldest.value) begin
            report_mismatch("value", out_value, oldest.value);
          end
          if (out_final_res !== oldest.fin) begin
            report_mismatch("final flag", out_final_res, oldest.fin);
          end
        end
      end
      if (in_valid && in_ready) begin
        decode_char(in_ch, in_last_char);
      end
    end
    outstanding <= owed_results.size();
  end

endmodule

[sim/bech32_charset_decode_test.sv]
// Testbench top for the bech32 character decoder: drives strings of
// characters with random gaps and stalls and gives the verdict.
// Depends on bcd_pkg, bech32_charset_decode and bcd_checker.
module bech32_charset_decode_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [255:0] BECH_SYMBOLS = "qpzry9x8gf2tvdw0s3jn54khce6mua7l";
  localparam int RANDOM_ITEMS  = 800;
  localparam int QUIET_LIMIT   = 3000;
  localparam int DRAIN_CYCLES  = 20;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_ready;
  logic [7:0] in_ch = 8'd0;
  logic       in_last_char = 1'b0;
  logic       out_valid;
  logic       out_ready = 1'b0;
  logic [1:0] out_kind;
  logic [7:0] out_value;
  logic       out_final_res;

  int         fail_count;
  int         outstanding;
  logic       calm = 1'b0;
  int         stall_left = 0;
  int         quiet_cycles = 0;
  int         random_sent = 0;
  logic [7:0] text_q[$];

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  bech32_charset_decode dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_ch        (in_ch),
    .in_last_char (in_last_char),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_kind     (out_kind),
    .out_value    (out_value),
    .out_final_res(out_final_res)
  );

  bcd_checker u_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_ch        (in_ch),
    .in_last_char (in_last_char),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_kind     (out_kind),
    .out_value    (out_value),
    .out_final_res(out_final_res),
    .fail_count   (fail_count),
    .outstanding  (outstanding)
  );

  // Idle length: mostly none or short, now and then long; none while calm.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (calm || r < 60) begin
      return 0;
    end
    if (r < 90) begin
      return $urandom_range(1, 3);
    end
    if (r < 98) begin
      return $urandom_range(4, 12);
    end
    return $urandom_range(20, 60);
  endfunction

  // Output back-pressure.
  always @(posedge clk) begin
    if (stall_left != 0) begin
      out_ready  <= 1'b0;
      stall_left <= stall_left - 1;
    end else begin
      stall_left <= pick_gap();
      out_ready  <= 1'b1;
    end
  end

  // Watchdog: ends the run when nothing moves for too long.
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && in_ready) || (out_valid && out_ready)) begin
        quiet_cycles <= 0;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("TB_ERROR");
        $finish;
      end
    end
  end

  function automatic logic [7:0] to_case(input logic [7:0] c, input logic upper);
    if (upper && c >= bcd_pkg::CH_LO_A && c <= bcd_pkg::CH_LO_Z) begin
      return c - bcd_pkg::CASE_OFS;
    end
    return c;
  endfunction

  function automatic logic [7:0] random_symbol(input logic upper);
    return to_case(BECH_SYMBOLS[8 * $urandom_range(0, 31) +: 8], upper);
  endfunction

  // Sends text_q, flagging its last character, and waits for acceptance.
  task automatic send_text();
    int gap;
    for (int i = 0; i < text_q.size(); i++) begin
      gap = pick_gap();
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      in_valid     <= 1'b1;
      in_ch        <= text_q[i];
      in_last_char <= (i == text_q.size() - 1);
      do @(posedge clk); while (!in_ready);
    end
  endtask

  // Builds one random string: mostly well-formed, some corrupted, some noise.
  task automatic make_random_text();
    int   shape;
    int   pos;
    logic upper;
    text_q.delete();
    shape = $urandom_range(0, 99);
    upper = ($urandom_range(0, 3) == 0);
    if (shape < 82) begin
      repeat ($urandom_range(0, 5)) begin
        text_q.push_back(to_case(bcd_pkg::CH_LO_A + 8'($urandom_range(0, 25)), upper));
      end
      text_q.push_back(bcd_pkg::CH_SEP);
      repeat ($urandom_range(0, 14)) text_q.push_back(random_symbol(upper));
      // Corrupt one character: a case flip on a letter, else a random byte.
      if (shape >= 70) begin
        pos = $urandom_range(0, text_q.size() - 1);
        if ($urandom_range(0, 1) == 0 &&
            ((text_q[pos] >= bcd_pkg::CH_LO_A && text_q[pos] <= bcd_pkg::CH_LO_Z) ||
             (text_q[pos] >= bcd_pkg::CH_UP_A && text_q[pos] <= bcd_pkg::CH_UP_Z))) begin
          text_q[pos] = text_q[pos] ^ bcd_pkg::CASE_OFS;
        end else begin
          text_q[pos] = 8'($urandom_range(0, 255));
        end
      end
    end else begin
      repeat ($urandom_range(1, 10)) begin
        case ($urandom_range(0, 3))
          0:       text_q.push_back(bcd_pkg::CH_SEP);
          1:       text_q.push_back(random_symbol(1'($urandom_range(0, 1))));
          default: text_q.push_back(8'($urandom_range(0, 255)));
        endcase
      end
    end
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed strings: byte extremes in the prefix and a dropped tail.
    text_q = '{8'h00, 8'hFF, bcd_pkg::CH_SEP, "l", "l", "l", "l"};
    send_text();
    // No separator at all.
    text_q = '{"x"};
    send_text();
    // Upper case prefix and data, then a second separator counts as bad.
    text_q = '{"A", bcd_pkg::CH_SEP, "Q", bcd_pkg::CH_SEP};
    send_text();
    // Byte above 127 after the separator.
    text_q = '{bcd_pkg::CH_SEP, "q", 8'h80};
    send_text();
    // Mixed case silences all later data results; only the end status follows.
    text_q = '{"a", bcd_pkg::CH_SEP, "Q", "P"};
    send_text();
    // A bad character outranks mixed case.
    text_q = '{"B", bcd_pkg::CH_SEP, "b"};
    send_text();
    // Separator alone.
    text_q = '{bcd_pkg::CH_SEP};
    send_text();

    // Random strings, with the odd calm stretch without any idling.
    while (random_sent < RANDOM_ITEMS) begin
      if ($urandom_range(0, 9) == 0) begin
        calm <= !calm;
      end
      make_random_text();
      send_text();
      random_sent += text_q.size();
    end

    in_valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0 && outstanding == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

[files.f]
design/bcd_pkg.sv
design/bcd_decode.sv
design/bcd_outq.sv
design/bech32_charset_decode.sv
sim/bcd_checker.sv
sim/bech32_charset_decode_test.sv
